FILE: rtl/bpa_pkg.sv
package bpa_pkg;

	localparam int MAX_PAGES     = 4096;
	localparam int WORD_BITS     = 64;
	localparam int MAP_WORDS     = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W       = $clog2(MAP_WORDS);
	localparam int BIT_W         = $clog2(WORD_BITS);
	localparam int PAGE_W        = 12;
	localparam int CNT_W         = 13;
	localparam int CFG_IDX_W     = 1;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WADDR_W-1:0]   waddr_t;
	typedef logic [BIT_W-1:0]     bidx_t;
	typedef logic [PAGE_W-1:0]    page_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	localparam cnt_t CNT_MAX   = {CNT_W{1'b1}};
	localparam cnt_t PAGES_CAP = CNT_W'(MAX_PAGES);

	// action codes
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_INIT  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_TOTAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		logic   clear_all;
		logic   rd_en;
		waddr_t rd_addr;
		logic   wr_en;
		waddr_t wr_addr;
		word_t  wr_data;
	} mem_req_t;

	typedef struct packed {
		logic    valid;
		status_t status;
		page_t   page;
		cnt_t    count;
	} result_t;

	// bits below n set
	function automatic word_t low_mask(input bidx_t n);
		return ~({WORD_BITS{1'b1}} << n);
	endfunction

	// index of the lowest set bit (0 when none)
	function automatic bidx_t first_one(input word_t v);
		bidx_t idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i])
				idx = BIT_W'(i);
		end
		return idx;
	endfunction

endpackage

FILE: rtl/bpa_map_mem.sv
module bpa_map_mem
	import bpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output word_t    rd_data
);

	word_t                mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] row_vld_q;
	word_t                data_s1;
	logic                 vld_s1;

	// row valid bits: a row never written since reset or init reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (req.clear_all)
				row_vld_q <= '0;
			else if (req.wr_en)
				row_vld_q[req.wr_addr] <= 1'b1;
			if (req.rd_en)
				vld_s1 <= row_vld_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			data_s1 <= mem[req.rd_addr];
	end

	assign rd_data = vld_s1 ? data_s1 : '0;

endmodule

FILE: rtl/bpa_ctrl.sv
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  page_t      page_index,
	input  cnt_t       page_total,
	input  cnt_t       reserved_count,
	input  logic       slot_free,
	input  word_t      rd_data,
	output mem_req_t   mem_req,
	output result_t    result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE,
		S_INIT,
		S_RESP
	} state_t;

	state_t  state_q;
	cnt_t    count_q;
	cnt_t    total_q;
	cnt_t    res_q;
	waddr_t  addr_q;
	waddr_t  chk_addr_s1;
	waddr_t  last_q;
	bidx_t   bit_q;
	status_t status_q;
	page_t   page_q;

	cnt_t    tot;
	cnt_t    res;
	cnt_t    tot_m1;
	cnt_t    res_m1;
	logic    in_range;
	word_t   scan_mask;
	word_t   avail;
	logic    hit;
	bidx_t   hit_bit;
	logic    bit_set;

	assign tot      = (page_total > PAGES_CAP) ? PAGES_CAP : page_total;
	assign res      = (reserved_count > tot) ? tot : reserved_count;
	assign tot_m1   = tot - 1'b1;
	assign res_m1   = res - 1'b1;
	assign in_range = {1'b0, page_index} < tot;
	assign in_ready = (state_q == S_IDLE);

	// pages of the checked word that lie below the managed total
	always_comb begin
		if ({1'b0, chk_addr_s1} < total_q[CNT_W-1:BIT_W])
			scan_mask = '1;
		else if ({1'b0, chk_addr_s1} == total_q[CNT_W-1:BIT_W])
			scan_mask = low_mask(total_q[BIT_W-1:0]);
		else
			scan_mask = '0;
	end

	assign avail   = ~rd_data & scan_mask;
	assign hit     = |avail;
	assign hit_bit = first_one(avail);
	assign bit_set = rd_data[bit_q];

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (action)
						ACT_ALLOC: begin
							mem_req.rd_en   = (tot != '0);
							mem_req.rd_addr = '0;
						end
						ACT_FREE: begin
							mem_req.rd_en   = in_range;
							mem_req.rd_addr = page_index[PAGE_W-1:BIT_W];
						end
						ACT_INIT: mem_req.clear_all = 1'b1;
						default: ;
					endcase
				end
			end
			S_ALLOC: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = addr_q;
				if (hit) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = chk_addr_s1;
					mem_req.wr_data = rd_data | (word_t'(1) << hit_bit);
				end
			end
			S_FREE: begin
				if (bit_set) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = addr_q;
					mem_req.wr_data = rd_data & ~(word_t'(1) << bit_q);
				end
			end
			S_INIT: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = addr_q;
				mem_req.wr_data = ({1'b0, addr_q} < res_q[CNT_W-1:BIT_W]) ?
					'1 : low_mask(res_q[BIT_W-1:0]);
			end
			S_RESP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			res_q       <= '0;
			addr_q      <= '0;
			chk_addr_s1 <= '0;
			last_q      <= '0;
			bit_q       <= '0;
			status_q    <= ST_OK;
			page_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						total_q  <= tot;
						status_q <= ST_OK;
						page_q   <= '0;
						unique case (action)
							ACT_ALLOC: begin
								if (tot == '0) begin
									status_q <= ST_OOM;
									state_q  <= S_RESP;
								end else begin
									addr_q      <= waddr_t'(1);
									chk_addr_s1 <= '0;
									last_q      <= tot_m1[PAGE_W-1:BIT_W];
									state_q     <= S_ALLOC;
								end
							end
							ACT_FREE: begin
								if (!in_range) begin
									status_q <= ST_INVALID;
									state_q  <= S_RESP;
								end else begin
									addr_q  <= page_index[PAGE_W-1:BIT_W];
									bit_q   <= page_index[BIT_W-1:0];
									state_q <= S_FREE;
								end
							end
							ACT_INIT: begin
								count_q <= tot - res;
								res_q   <= res;
								addr_q  <= '0;
								last_q  <= res_m1[PAGE_W-1:BIT_W];
								state_q <= (res == '0) ? S_RESP : S_INIT;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_ALLOC: begin
					if (hit) begin
						page_q  <= {chk_addr_s1, hit_bit};
						if (count_q != '0)
							count_q <= count_q - 1'b1;
						state_q <= S_RESP;
					end else if (chk_addr_s1 == last_q) begin
						status_q <= ST_OOM;
						state_q  <= S_RESP;
					end else begin
						chk_addr_s1 <= addr_q;
						addr_q      <= addr_q + 1'b1;
					end
				end
				S_FREE: begin
					if (bit_set && count_q != CNT_MAX)
						count_q <= count_q + 1'b1;
					state_q <= S_RESP;
				end
				S_INIT: begin
					if (addr_q == last_q)
						state_q <= S_RESP;
					else
						addr_q <= addr_q + 1'b1;
				end
				S_RESP: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid  = (state_q == S_RESP);
	assign result.status = status_q;
	assign result.page   = page_q;
	assign result.count  = count_q;

endmodule

FILE: rtl/bitmap_page_allocator.sv
// First-fit bitmap page allocator: one used bit per page, 64 pages per map word.
// Input channel (in_valid/in_ready) carries action and page_index; each input
// transaction gives exactly one output transaction (status, granted_page,
// free_count) on out_valid/out_ready. page_total and reserved_count are
// written through cfg_wr_en/cfg_index/cfg_data; the user must write them only
// while the block is idle, and the block itself does not enforce this.
// Steps: allocate reads 1..64 map words, one per cycle, and writes a hit
// back in the same cycle; free in range reads, modifies/writes and responds;
// init writes ceil(reserved/64) map words, one per cycle, then responds;
// out-of-range free, empty allocate and unknown action just respond.
// The result sits in an output register, so the next transaction is taken
// while the previous result waits; the controller holds its next result
// while that register is still full, and then in_ready stays low.
// Reset: map reads as all free (per-word valid bits cleared at once),
// free count zero, page_total 4096, reserved_count 0. Ready right away.
module bitmap_page_allocator
	import bpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  page_t                page_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output page_t                granted_page,
	output cnt_t                 free_count,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  cnt_t                 cfg_data
);

	cnt_t     page_total_q;
	cnt_t     reserved_q;
	logic     out_valid_q;
	status_t  status_q;
	page_t    granted_q;
	cnt_t     count_q;
	logic     slot_free;
	mem_req_t mem_req;
	word_t    rd_data;
	result_t  result;

	// configuration registers; take effect on the next transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_total_q <= PAGES_CAP;
			reserved_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PAGE_TOTAL: page_total_q <= cfg_data;
				CFG_RESERVED:   reserved_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register is free when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;

	bpa_map_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	bpa_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.page_index     (page_index),
		.page_total     (page_total_q),
		.reserved_count (reserved_q),
		.slot_free      (slot_free),
		.rd_data        (rd_data),
		.mem_req        (mem_req),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			granted_q   <= '0;
			count_q     <= '0;
		end else if (slot_free) begin
			out_valid_q <= result.valid;
			if (result.valid) begin
				status_q  <= result.status;
				granted_q <= result.page;
				count_q   <= result.count;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_page = granted_q;
	assign free_count   = count_q;

	// every accepted transaction takes the controller out of idle, so in_ready drops
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// map clear and map write never coincide
	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.clear_all && mem_req.wr_en))
		else $error("map clear collides with write");

	// a finished result with room in the output register shows up next cycle
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && slot_free |=> out_valid)
		else $error("result lost");

	// failed allocate or free grants nothing
	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OOM || status == ST_INVALID) |-> granted_page == '0)
		else $error("page granted with error status");

endmodule
